FILE: rtl/coalescing_event_queue_macros.svh
// Assertion macros for the coalescing event queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COALESCING_EVENT_QUEUE_MACROS_SVH
`define COALESCING_EVENT_QUEUE_MACROS_SVH

// Checked only outside reset.
`define CEQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("coalescing event queue check failed");

// Checked at every edge, reset included.
`define CEQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("coalescing event queue reset check failed");

`endif

FILE: rtl/ceq_pkg.sv
// Shared types and codes for the coalescing event queue.
// No dependencies; imported by the controller, datapath, top level and checker.
package ceq_pkg;

    localparam logic       ACT_QUEUE = 1'b0;
    localparam logic       ACT_FLUSH = 1'b1;

    localparam logic [1:0] RT_ACK    = 2'd0;
    localparam logic [1:0] RT_EVENT  = 2'd1;
    localparam logic [1:0] RT_EMPTY  = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [31:0] event_key;
        logic [2:0]  event_kind;
        logic [63:0] event_payload;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_type;
        logic        flush_wanted;
        logic        dropped;
        logic [2:0]  out_kind;
        logic [31:0] out_key;
        logic [63:0] out_payload;
        logic [15:0] merge_count;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [63:0] payload;
        logic [15:0] cnt;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // take the input beat and its match result
        logic commit;       // finish a queue request, load acknowledge
        logic flush_pop;    // move head entry out, shift chain down
        logic flush_empty;  // load the empty-flush result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic occ_zero;
        logic occ_one;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/ceq_ctrl.sv
// Sequencer of the coalescing event queue: accept, commit, flush drain.
// Depends on ceq_pkg for the command and status structs.
module ceq_ctrl
    import ceq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action,
    output logic     o_in_ready,
    input  t_stat    i_stat,
    output t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_COMMIT = 2'd1;
    localparam logic [1:0] S_FLUSH  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_action == ACT_FLUSH) ? S_FLUSH : S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    if (i_stat.occ_zero) begin
                        o_cmd.flush_empty = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.flush_pop = 1'b1;
                        if (i_stat.occ_one) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/ceq_dp.sv
// Datapath of the coalescing event queue: entry cell chain, key match,
// occupancy and the output register. Depends on ceq_pkg.
module ceq_dp
    import ceq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_beat,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry          r_ent [QUEUE_DEPTH];
    t_entry          w_up  [QUEUE_DEPTH];
    logic [CW-1:0]   r_occ;
    t_in_beat        r_in;
    logic            r_found;
    logic [IW-1:0]   r_pos;
    logic [15:0]     r_sel_cnt;
    logic            r_out_valid;
    t_out_beat       r_out;
    t_out_beat       n_out;

    logic            w_found;
    logic [IW-1:0]   w_pos;
    logic [15:0]     w_sel_cnt;
    logic            w_want;
    logic            w_drop;
    logic [CW-1:0]   w_tail;
    logic [15:0]     w_new_cnt;
    t_entry          w_new;

    // neighbor one place toward the tail, for compaction and drain
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_up
            if (g < QUEUE_DEPTH - 1) begin : g_mid
                assign w_up[g] = r_ent[g + 1];
            end else begin : g_end
                assign w_up[g] = '0;
            end
        end
    endgenerate

    // keys held are unique, so at most one cell hits; OR-combine
    always_comb begin
        w_found   = 1'b0;
        w_pos     = '0;
        w_sel_cnt = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((CW'(i) < r_occ) && (r_ent[i].key == i_in_beat.event_key)) begin
                w_found   = 1'b1;
                w_pos     = w_pos | IW'(i);
                w_sel_cnt = w_sel_cnt | r_ent[i].cnt;
            end
        end
    end

    always_comb begin
        w_want    = (r_occ == '0);
        w_drop    = !r_found && (r_occ == CW'(QUEUE_DEPTH));
        w_tail    = r_found ? (r_occ - CW'(1)) : r_occ;
        w_new_cnt = !r_found ? 16'd1 :
                    (r_sel_cnt == COUNT_MAX) ? COUNT_MAX : (r_sel_cnt + 16'd1);
        w_new.kind    = r_in.event_kind;
        w_new.key     = r_in.event_key;
        w_new.payload = r_in.event_payload;
        w_new.cnt     = w_new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in      <= i_in_beat;
            r_found   <= w_found;
            r_pos     <= w_pos;
            r_sel_cnt <= w_sel_cnt;
        end
    end

    // cell chain: tail write wins over the shift
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.commit && !w_drop && (CW'(i) == w_tail)) begin
                r_ent[i] <= w_new;
            end else if (i_cmd.flush_pop ||
                         (i_cmd.commit && r_found && (IW'(i) >= r_pos))) begin
                r_ent[i] <= w_up[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.commit && !r_found && !w_drop) begin
            r_occ <= r_occ + CW'(1);
        end else if (i_cmd.flush_pop) begin
            r_occ <= r_occ - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.flush_pop || i_cmd.flush_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next result beat; unused fields stay zero
    always_comb begin
        n_out = '0;
        if (i_cmd.commit) begin
            n_out.result_type  = RT_ACK;
            n_out.flush_wanted = w_want;
            n_out.dropped      = w_drop;
            n_out.merge_count  = w_drop ? 16'd0 : w_new_cnt;
            n_out.last         = 1'b1;
        end else if (i_cmd.flush_pop) begin
            n_out.result_type  = RT_EVENT;
            n_out.out_kind     = r_ent[0].kind;
            n_out.out_key      = r_ent[0].key;
            n_out.out_payload  = r_ent[0].payload;
            n_out.merge_count  = r_ent[0].cnt;
            n_out.last         = (r_occ == CW'(1));
        end else if (i_cmd.flush_empty) begin
            n_out.result_type  = RT_EMPTY;
            n_out.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.flush_pop || i_cmd.flush_empty) begin
            r_out <= n_out;
        end
    end

    assign o_stat.occ_zero = (r_occ == '0);
    assign o_stat.occ_one  = (r_occ == CW'(1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_beat      = r_out;

endmodule

FILE: rtl/coalescing_event_queue.sv
// Top level of the coalescing event queue: controller plus datapath.
// Depends on ceq_pkg, ceq_ctrl and ceq_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_beat): one beat is a
//   queue request (action 0) or a flush request (action 1).
//   Output channel (o_out_valid / i_out_ready / o_out_beat): result beats.
//   A queue request gives one acknowledge beat; a flush gives one beat per
//   held entry, oldest first, last set on the final one, or a single
//   empty-flush beat when nothing is held.
// Sequence and rate:
//   A queue request: the accept edge registers the key match over all cells;
//   in the commit state, once the output is free, the cell chain compacts
//   and the acknowledge loads. A flush is accepted, then shifts out one entry
//   per cycle from the head of the chain while the output register is free.
//   o_in_ready is high only while no request is in progress; a request can
//   be accepted while the previous result still waits in the output register.
// Reset: synchronous, active low; empties the queue and the output register.
// Stall: while i_out_ready is low the output beat holds and the sequencer
//   waits; no result is lost or repeated.
module coalescing_event_queue
    import ceq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one request at a time
    ceq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_beat.action),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // cell chain, match logic, output register
    ceq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

FILE: rtl/ceq_checker.sv
// Port-level checks for the coalescing event queue, bound to the top level.
// Depends on ceq_pkg and coalescing_event_queue_macros.svh.
`include "coalescing_event_queue_macros.svh"

module ceq_checker
    import ceq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a stalled result beat holds
    `CEQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))

    // one request at a time
    `CEQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // acknowledges and empty flushes are single-beat results
    `CEQ_ASSERT(a_single_last, i_clk, i_rst_n, o_out_valid && (o_out_beat.result_type != RT_EVENT) |-> o_out_beat.last)

    // reset leaves an idle block with nothing to deliver
    `CEQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

endmodule

bind coalescing_event_queue ceq_checker u_ceq_checker (.*);
